FILE: hw/rtl/mct_pkg.sv
// Types, constants and helper functions for the mouse click and cursor tracker.
// No dependencies; imported by mct_core and mouse_click_and_cursor_tracker.
`timescale 1ns / 1ps

package mct_pkg;

    // Configuration register indexes
    localparam logic [1:0] CFG_X_LOW   = 2'd0;
    localparam logic [1:0] CFG_X_LIMIT = 2'd1;
    localparam logic [1:0] CFG_Y_LOW   = 2'd2;
    localparam logic [1:0] CFG_Y_LIMIT = 2'd3;

    localparam logic [15:0] RST_X_LOW   = 16'h0000;
    localparam logic [15:0] RST_X_LIMIT = 16'h0100;
    localparam logic [15:0] RST_Y_LOW   = 16'h0000;
    localparam logic [15:0] RST_Y_LIMIT = 16'h00E0;

    localparam logic [7:0] RST_LAST_POS = 8'h80;

    // Button byte bits
    localparam logic [7:0] BTN_LEFT_HELD  = 8'h11;
    localparam logic [7:0] BTN_LEFT_EDGE  = 8'h22;
    localparam logic [7:0] BTN_RIGHT_HELD = 8'h02;
    localparam logic [7:0] BTN_RIGHT_EDGE = 8'h04;
    localparam logic [7:0] BTN_EDGE_MASK  = 8'h22;

    localparam logic [5:0] REPEAT_FRAMES = 6'd32;

    // Motion codes
    localparam logic [3:0] MOTION_MOVED = 4'h1;
    localparam logic [3:0] MOTION_STILL = 4'h4;

    typedef struct packed {
        logic       mouse_enabled;
        logic       mouse_present;
        logic       position_valid;
        logic [7:0] position_x;
        logic [7:0] position_y;
        logic       left_button;
        logic       right_button;
        logic [1:0] sensitivity;
    } t_sample;

    typedef struct packed {
        logic [15:0] x_low;
        logic [15:0] x_limit;
        logic [15:0] y_low;
        logic [15:0] y_limit;
    } t_bounds;

    typedef struct packed {
        logic [7:0]  move_x;
        logic [7:0]  move_y;
        logic [7:0]  button_bits;
        logic [1:0]  sensitivity_out;
        logic        mouse_seen;
        logic [15:0] pointer_x;
        logic [15:0] pointer_y;
        logic [3:0]  motion_code;
    } t_result;

    // Clamp a 9-bit signed delta to +/-127 and code it as sign-magnitude
    function automatic logic [7:0] code_disp(input logic signed [8:0] d);
        logic signed [8:0] c;
        logic [8:0]        m;
        c = d;
        if (d > 9'sd127) c = 9'sd127;
        if (d < -9'sd127) c = -9'sd127;
        if (c < 9'sd0) begin
            m = 9'(-c);
            return {1'b1, m[6:0]};
        end
        m = 9'(c);
        return {1'b0, m[6:0]};
    endfunction

    // Apply a sign-magnitude step; keep the old position if the new one is out of bounds
    function automatic logic [15:0] move_axis(input logic [15:0] pos, input logic [7:0] disp,
                                              input logic [15:0] lo, input logic [15:0] lim);
        logic [15:0] mag;
        logic [15:0] np;
        mag = {9'd0, disp[6:0]};
        np  = disp[7] ? (pos - mag) : (pos + mag);
        if (($signed(np) < $signed(lim)) && ($signed(np) >= $signed(lo)))
            return np;
        return pos;
    endfunction

endpackage

FILE: hw/rtl/mct_core.sv
// Per-frame tracker logic: displacement coding, button byte, repeat timer, cursor update.
// Holds the frame-to-frame state; depends on mct_pkg.
`timescale 1ns / 1ps

module mct_core (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_fire,
    input  mct_pkg::t_sample i_sample,
    input  mct_pkg::t_bounds i_bounds,
    output mct_pkg::t_result o_result
);
    import mct_pkg::*;

    logic [7:0]  r_last_pos_x, n_last_pos_x;
    logic [7:0]  r_last_pos_y, n_last_pos_y;
    logic        r_last_left, n_last_left;
    logic        r_last_right, n_last_right;
    logic [7:0]  r_repeat_mask, n_repeat_mask;
    logic [5:0]  r_repeat_count, n_repeat_count;
    logic        r_seen, n_seen;
    logic [15:0] r_cur_x, n_cur_x;
    logic [15:0] r_cur_y, n_cur_y;
    logic [2:0]  r_last_motion, n_last_motion;

    logic              w_active;
    logic signed [8:0] w_dx, w_dy;
    logic [7:0]        w_mx, w_my, w_btn, w_matched;
    logic [5:0]        w_cnt_dec;
    logic [3:0]        w_moved, w_code;

    assign w_active = i_sample.mouse_enabled && i_sample.mouse_present;
    assign w_dx = 9'($signed({1'b0, i_sample.position_x}) - $signed({1'b0, r_last_pos_x}));
    assign w_dy = 9'($signed({1'b0, i_sample.position_y}) - $signed({1'b0, r_last_pos_y}));
    assign w_cnt_dec = r_repeat_count - 6'd1;

    always_comb begin
        n_last_pos_x   = r_last_pos_x;
        n_last_pos_y   = r_last_pos_y;
        n_last_left    = r_last_left;
        n_last_right   = r_last_right;
        n_repeat_mask  = r_repeat_mask;
        n_repeat_count = r_repeat_count;
        n_seen         = r_seen;
        w_mx           = 8'd0;
        w_my           = 8'd0;
        w_btn          = 8'd0;
        w_matched      = 8'd0;

        if (w_active) begin
            n_seen = 1'b1;
            if (i_sample.position_valid) begin
                w_mx         = code_disp(w_dx);
                w_my         = code_disp(w_dy);
                n_last_pos_x = i_sample.position_x;
                n_last_pos_y = i_sample.position_y;
            end

            if (i_sample.left_button) w_btn = w_btn | BTN_LEFT_HELD;
            if (i_sample.left_button && !r_last_left) w_btn = w_btn | BTN_LEFT_EDGE;
            if (i_sample.right_button) w_btn = w_btn | BTN_RIGHT_HELD;
            if (i_sample.right_button && !r_last_right) w_btn = w_btn | BTN_RIGHT_EDGE;
            n_last_left  = i_sample.left_button;
            n_last_right = i_sample.right_button;

            // Repeat timer: arm on a press edge, cancel on motion, fire after 32 still frames
            priority if (r_repeat_count == 6'd0) begin
                if ((w_btn & BTN_EDGE_MASK) != 8'd0) begin
                    n_repeat_mask  = w_btn & BTN_EDGE_MASK;
                    n_repeat_count = REPEAT_FRAMES;
                end
            end else if ((w_mx != 8'd0) || (w_my != 8'd0)) begin
                n_repeat_count = 6'd0;
                n_repeat_mask  = 8'd0;
            end else begin
                n_repeat_count = w_cnt_dec;
                w_matched      = w_btn & BTN_EDGE_MASK & r_repeat_mask;
                if ((w_cnt_dec == 6'd0) && (w_matched != 8'd0))
                    w_btn = w_btn | {w_matched[5:0], 2'b00};
            end
        end
    end

    assign n_cur_x = move_axis(r_cur_x, w_mx, i_bounds.x_low, i_bounds.x_limit);
    assign n_cur_y = move_axis(r_cur_y, w_my, i_bounds.y_low, i_bounds.y_limit);

    assign w_moved = ((w_mx[6:0] != 7'd0) || (w_my[6:0] != 7'd0)) ? MOTION_MOVED : MOTION_STILL;
    assign w_code  = {((w_moved[2:0] ^ r_last_motion) & w_moved[2:0]), 1'b0} | w_moved;
    assign n_last_motion = w_moved[2:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_pos_x   <= RST_LAST_POS;
            r_last_pos_y   <= RST_LAST_POS;
            r_last_left    <= 1'b0;
            r_last_right   <= 1'b0;
            r_repeat_mask  <= 8'd0;
            r_repeat_count <= 6'd0;
            r_seen         <= 1'b0;
            r_cur_x        <= 16'd0;
            r_cur_y        <= 16'd0;
            r_last_motion  <= 3'd0;
        end else if (i_fire) begin
            r_last_pos_x   <= n_last_pos_x;
            r_last_pos_y   <= n_last_pos_y;
            r_last_left    <= n_last_left;
            r_last_right   <= n_last_right;
            r_repeat_mask  <= n_repeat_mask;
            r_repeat_count <= n_repeat_count;
            r_seen         <= n_seen;
            r_cur_x        <= n_cur_x;
            r_cur_y        <= n_cur_y;
            r_last_motion  <= n_last_motion;
        end
    end

    assign o_result.move_x          = w_mx;
    assign o_result.move_y          = w_my;
    assign o_result.button_bits     = w_btn;
    assign o_result.sensitivity_out = w_active ? i_sample.sensitivity : 2'd0;
    assign o_result.mouse_seen      = n_seen;
    assign o_result.pointer_x       = n_cur_x;
    assign o_result.pointer_y       = n_cur_y;
    assign o_result.motion_code     = w_code;

endmodule

FILE: hw/rtl/mouse_click_and_cursor_tracker.sv
// Top level: stream ports, sample register, bounds registers, result register.
// Depends on mct_pkg and mct_core.
//
//   channel  | dir | payload
//   s_axis   | in  | 24-bit tdata: one frame sample
//   m_axis   | out | 64-bit tdata: displacement, buttons, sensitivity, seen flag, cursor, motion code
//   cfg      | in  | index 0..3 selects x_low, x_limit, y_low, y_limit; 16-bit data
//
// One sample per cycle sustained while the output is not stalled; an input transaction reaches
// the result through the sample register, then the result register behind the tracker logic.
// Reset is synchronous; it clears state, restores default bounds and empties both stages.
// A stalled result holds the stage; the sample register keeps accepting until it is full.
`timescale 1ns / 1ps

module mouse_click_and_cursor_tracker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // [0] mouse_enabled, [1] mouse_present, [2] position_valid, [10:3] position_x,
    // [18:11] position_y, [19] left_button, [20] right_button, [22:21] sensitivity
    input  logic [23:0] i_s_axis_tdata,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] move_x, [15:8] move_y, [23:16] button_bits, [25:24] sensitivity_out,
    // [26] mouse_seen, [42:27] pointer_x, [58:43] pointer_y, [62:59] motion_code
    output logic [63:0] o_m_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic        i_cfg_wr_en,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_wdata
);
    import mct_pkg::*;

    t_sample r_sample;
    logic    r_in_valid, n_in_valid;
    t_result r_result;
    logic    r_out_valid, n_out_valid;
    t_bounds r_bounds;
    t_result w_result;
    logic    w_adv, w_in_acc, w_fire;

    assign w_adv           = !r_out_valid || i_m_axis_tready;
    assign o_s_axis_tready = !r_in_valid || w_adv;
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_fire          = r_in_valid && w_adv;

    assign n_in_valid  = w_in_acc ? 1'b1 : (w_fire ? 1'b0 : r_in_valid);
    assign n_out_valid = w_fire ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_out_valid);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_sample.mouse_enabled  <= i_s_axis_tdata[0];
            r_sample.mouse_present  <= i_s_axis_tdata[1];
            r_sample.position_valid <= i_s_axis_tdata[2];
            r_sample.position_x     <= i_s_axis_tdata[10:3];
            r_sample.position_y     <= i_s_axis_tdata[18:11];
            r_sample.left_button    <= i_s_axis_tdata[19];
            r_sample.right_button   <= i_s_axis_tdata[20];
            r_sample.sensitivity    <= i_s_axis_tdata[22:21];
        end
        if (w_fire) r_result <= w_result;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bounds.x_low   <= RST_X_LOW;
            r_bounds.x_limit <= RST_X_LIMIT;
            r_bounds.y_low   <= RST_Y_LOW;
            r_bounds.y_limit <= RST_Y_LIMIT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_X_LOW:   r_bounds.x_low   <= i_cfg_wdata;
                CFG_X_LIMIT: r_bounds.x_limit <= i_cfg_wdata;
                CFG_Y_LOW:   r_bounds.y_low   <= i_cfg_wdata;
                CFG_Y_LIMIT: r_bounds.y_limit <= i_cfg_wdata;
                default:     r_bounds         <= r_bounds;
            endcase
        end
    end

    mct_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_sample (r_sample),
        .i_bounds (r_bounds),
        .o_result (w_result)
    );

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0,
                              r_result.motion_code,
                              r_result.pointer_y,
                              r_result.pointer_x,
                              r_result.mouse_seen,
                              r_result.sensitivity_out,
                              r_result.button_bits,
                              r_result.move_y,
                              r_result.move_x};

endmodule
